>>> rtl/core/gsa_pkg.sv
// Shared constants, codes and types of the generational slot allocator.
// Depends on nothing; used by every module under rtl/core except gsa_ram.
package gsa_pkg;

   localparam int SLOT_COUNT = 64;
   localparam int GEN_BITS   = 24;
   localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int CNT_W      = $clog2(SLOT_COUNT + 1);

   localparam int HANDLE_W = 32;
   localparam int HIDX_W   = 8;
   localparam int HGEN_W   = HANDLE_W - HIDX_W;
   localparam int OWNER_W  = 32;
   localparam int ACTION_W = 3;
   localparam int STATUS_W = 2;
   localparam int RCNT_W   = 7;

   typedef enum logic [ACTION_W-1:0] {
      ACT_ALLOC     = 3'd0,
      ACT_RELEASE   = 3'd1,
      ACT_LOOKUP    = 3'd2,
      ACT_REL_OWNER = 3'd3,
      ACT_REL_ALL   = 3'd4
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_BAD_ID    = 2'd2,
      ST_BAD_OWNER = 2'd3
   } status_type;

   typedef struct packed {
      logic       load;
      logic       set_status;
      status_type status;
      logic       pop_rd;
      logic       gen_rd;
      logic       alloc_new;
      logic       alloc_reuse;
      logic       slot_rd;
      logic       free_one;
      logic       lookup_done;
      logic       walk_step;
   } dp_cmd_type;

   typedef struct packed {
      action_type action;
      logic       owner_zero;
      logic       stack_empty;
      logic       table_full;
      logic       id_in_range;
      logic       slot_hit;
      logic       walk_done;
   } dp_stat_type;

   function automatic logic [HANDLE_W-1:0] make_handle(input logic [IDX_W-1:0] idx,
                                                        input logic [GEN_BITS-1:0] gen);
      logic [HIDX_W-1:0] low;
      low = HIDX_W'(idx) + HIDX_W'(1);
      return {HGEN_W'(gen), low};
   endfunction

endpackage

>>> rtl/core/gsa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gsa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                        clock,
   input  logic                                        we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                            wdata,
   input  logic                                        re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                            rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/core/gsa_dp.sv
// Datapath: slot tables (generation, owner, free stack RAMs), valid bits,
// counters and result registers. Depends on gsa_pkg and gsa_ram.
module gsa_dp (
   input  logic                           clock,
   input  logic                           reset,
   input  gsa_pkg::dp_cmd_type            cmd,
   output gsa_pkg::dp_stat_type           stat,
   input  logic [gsa_pkg::ACTION_W-1:0]   req_action,
   input  logic [gsa_pkg::HANDLE_W-1:0]   req_instance_id,
   input  logic [gsa_pkg::OWNER_W-1:0]    req_owner_tag,
   output logic [gsa_pkg::HANDLE_W-1:0]   rsp_result_id,
   output logic [gsa_pkg::STATUS_W-1:0]   rsp_status,
   output logic [gsa_pkg::OWNER_W-1:0]    rsp_owner_out,
   output logic [gsa_pkg::RCNT_W-1:0]     rsp_released_count
);

   gsa_pkg::action_type                action_ff, action_in;
   logic [gsa_pkg::HANDLE_W-1:0]       id_ff, id_in;
   logic [gsa_pkg::OWNER_W-1:0]        owner_ff, owner_in;
   logic [gsa_pkg::HANDLE_W-1:0]       res_id_ff, res_id_in;
   gsa_pkg::status_type                status_ff, status_in;
   logic [gsa_pkg::OWNER_W-1:0]        owner_out_ff, owner_out_in;
   logic [gsa_pkg::CNT_W-1:0]          released_ff, released_in;
   logic [gsa_pkg::CNT_W-1:0]          mark_ff, mark_in;
   logic [gsa_pkg::CNT_W-1:0]          fsc_ff, fsc_in;
   logic [gsa_pkg::SLOT_COUNT-1:0]     valid_ff, valid_in;
   logic [gsa_pkg::IDX_W-1:0]          idx_ff, idx_in;
   logic [gsa_pkg::CNT_W-1:0]          walk_ff, walk_in;
   logic                               pend_ff, pend_in;
   logic [gsa_pkg::IDX_W-1:0]          pend_idx_ff, pend_idx_in;

   logic [gsa_pkg::GEN_BITS-1:0]       gen_rdata;
   logic [gsa_pkg::OWNER_W-1:0]        owner_rdata;
   logic [gsa_pkg::IDX_W-1:0]          fs_rdata;

   logic [gsa_pkg::HIDX_W-1:0]         id_low;
   logic [gsa_pkg::HIDX_W-1:0]         id_idx_full;
   logic [gsa_pkg::IDX_W-1:0]          id_idx;
   logic [gsa_pkg::IDX_W-1:0]          mark_idx;
   logic [gsa_pkg::CNT_W-1:0]          fsc_dec;
   logic                               walk_issue;
   logic                               walk_hit;
   logic                               do_free;
   logic [gsa_pkg::IDX_W-1:0]          free_idx;

   logic                               rd_en;
   logic [gsa_pkg::IDX_W-1:0]          rd_addr;
   logic                               gen_we;
   logic [gsa_pkg::IDX_W-1:0]          gen_waddr;
   logic [gsa_pkg::GEN_BITS-1:0]       gen_wdata;
   logic                               own_we;
   logic [gsa_pkg::IDX_W-1:0]          own_waddr;

   assign id_low      = id_ff[gsa_pkg::HIDX_W-1:0];
   assign id_idx_full = id_low - gsa_pkg::HIDX_W'(1);
   assign id_idx      = id_idx_full[gsa_pkg::IDX_W-1:0];
   assign mark_idx    = mark_ff[gsa_pkg::IDX_W-1:0];
   assign fsc_dec     = fsc_ff - gsa_pkg::CNT_W'(1);

   assign walk_issue = cmd.walk_step && (walk_ff < mark_ff);
   assign walk_hit   = pend_ff && valid_ff[pend_idx_ff] &&
                       ((action_ff == gsa_pkg::ACT_REL_ALL) || (owner_rdata == owner_ff));
   assign do_free    = cmd.free_one || (cmd.walk_step && walk_hit);
   assign free_idx   = cmd.free_one ? idx_ff : pend_idx_ff;

   assign stat.action      = action_ff;
   assign stat.owner_zero  = (owner_ff == '0);
   assign stat.stack_empty = (fsc_ff == '0);
   assign stat.table_full  = (mark_ff >= gsa_pkg::CNT_W'(gsa_pkg::SLOT_COUNT));
   assign stat.id_in_range = (id_low != '0) && (id_idx_full < gsa_pkg::HIDX_W'(mark_ff));
   assign stat.slot_hit    = valid_ff[idx_ff] &&
                             (gsa_pkg::HGEN_W'(gen_rdata) ==
                              id_ff[gsa_pkg::HANDLE_W-1:gsa_pkg::HIDX_W]);
   assign stat.walk_done   = (walk_ff >= mark_ff) && !pend_ff;

   // shared read address for generation and owner tables, and their write controls
   always_comb begin
      rd_en = cmd.gen_rd || cmd.slot_rd || walk_issue;
      if (cmd.gen_rd) begin
         rd_addr = fs_rdata;
      end else if (cmd.slot_rd) begin
         rd_addr = id_idx;
      end else begin
         rd_addr = walk_ff[gsa_pkg::IDX_W-1:0];
      end
      gen_we    = cmd.alloc_new || do_free;
      gen_waddr = cmd.alloc_new ? mark_idx : free_idx;
      gen_wdata = cmd.alloc_new ? '0 : gen_rdata + gsa_pkg::GEN_BITS'(1);
      own_we    = cmd.alloc_new || cmd.alloc_reuse;
      own_waddr = cmd.alloc_new ? mark_idx : idx_ff;
   end

   gsa_ram #(.WIDTH(gsa_pkg::GEN_BITS), .DEPTH(gsa_pkg::SLOT_COUNT)) u_gen_ram (
      .clock (clock),
      .we    (gen_we),
      .waddr (gen_waddr),
      .wdata (gen_wdata),
      .re    (rd_en),
      .raddr (rd_addr),
      .rdata (gen_rdata)
   );

   gsa_ram #(.WIDTH(gsa_pkg::OWNER_W), .DEPTH(gsa_pkg::SLOT_COUNT)) u_owner_ram (
      .clock (clock),
      .we    (own_we),
      .waddr (own_waddr),
      .wdata (owner_ff),
      .re    (rd_en),
      .raddr (rd_addr),
      .rdata (owner_rdata)
   );

   gsa_ram #(.WIDTH(gsa_pkg::IDX_W), .DEPTH(gsa_pkg::SLOT_COUNT)) u_stack_ram (
      .clock (clock),
      .we    (do_free),
      .waddr (fsc_ff[gsa_pkg::IDX_W-1:0]),
      .wdata (free_idx),
      .re    (cmd.pop_rd),
      .raddr (fsc_dec[gsa_pkg::IDX_W-1:0]),
      .rdata (fs_rdata)
   );

   always_comb begin
      action_in    = action_ff;
      id_in        = id_ff;
      owner_in     = owner_ff;
      res_id_in    = res_id_ff;
      status_in    = status_ff;
      owner_out_in = owner_out_ff;
      released_in  = released_ff;
      mark_in      = mark_ff;
      fsc_in       = fsc_ff;
      valid_in     = valid_ff;
      idx_in       = idx_ff;
      walk_in      = walk_ff;
      pend_in      = pend_ff;
      pend_idx_in  = pend_idx_ff;

      if (cmd.load) begin
         action_in    = gsa_pkg::action_type'(req_action);
         id_in        = req_instance_id;
         owner_in     = req_owner_tag;
         res_id_in    = '0;
         status_in    = gsa_pkg::ST_OK;
         owner_out_in = '0;
         released_in  = '0;
         walk_in      = '0;
         pend_in      = 1'b0;
      end
      if (cmd.set_status) begin
         status_in = cmd.status;
      end
      if (cmd.pop_rd) begin
         fsc_in = fsc_dec;
      end
      if (cmd.gen_rd) begin
         idx_in = fs_rdata;
      end
      if (cmd.slot_rd) begin
         idx_in = id_idx;
      end
      if (cmd.alloc_new) begin
         mark_in            = mark_ff + gsa_pkg::CNT_W'(1);
         valid_in[mark_idx] = 1'b1;
         res_id_in          = gsa_pkg::make_handle(mark_idx, '0);
      end
      if (cmd.alloc_reuse) begin
         valid_in[idx_ff] = 1'b1;
         res_id_in        = gsa_pkg::make_handle(idx_ff, gen_rdata);
      end
      if (cmd.lookup_done) begin
         owner_out_in = owner_rdata;
      end
      if (cmd.walk_step) begin
         pend_in     = walk_issue;
         pend_idx_in = walk_ff[gsa_pkg::IDX_W-1:0];
         if (walk_issue) begin
            walk_in = walk_ff + gsa_pkg::CNT_W'(1);
         end
      end
      if (do_free) begin
         valid_in[free_idx] = 1'b0;
         fsc_in             = fsc_ff + gsa_pkg::CNT_W'(1);
         released_in        = released_ff + gsa_pkg::CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mark_ff  <= '0;
         fsc_ff   <= '0;
         valid_ff <= '0;
         walk_ff  <= '0;
         pend_ff  <= 1'b0;
      end else begin
         mark_ff  <= mark_in;
         fsc_ff   <= fsc_in;
         valid_ff <= valid_in;
         walk_ff  <= walk_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff    <= action_in;
      id_ff        <= id_in;
      owner_ff     <= owner_in;
      res_id_ff    <= res_id_in;
      status_ff    <= status_in;
      owner_out_ff <= owner_out_in;
      released_ff  <= released_in;
      idx_ff       <= idx_in;
      pend_idx_ff  <= pend_idx_in;
   end

   assign rsp_result_id      = res_id_ff;
   assign rsp_status         = status_ff;
   assign rsp_owner_out      = owner_out_ff;
   assign rsp_released_count = gsa_pkg::RCNT_W'(released_ff);

endmodule

>>> rtl/core/gsa_ctrl.sv
// Control state machine: sequences table reads, writes and slot walks.
// Depends on gsa_pkg; drives gsa_dp through command/status structs.
module gsa_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   output logic                  rsp_valid,
   output gsa_pkg::dp_cmd_type   cmd,
   input  gsa_pkg::dp_stat_type  stat
);

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_DECODE = 7'b0000010,
      S_POP    = 7'b0000100,
      S_GEN    = 7'b0001000,
      S_SLOT   = 7'b0010000,
      S_WALK   = 7'b0100000,
      S_RESP   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            case (stat.action)
               gsa_pkg::ACT_ALLOC: begin
                  if (stat.owner_zero) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = gsa_pkg::ST_BAD_OWNER;
                     state_in       = S_RESP;
                  end else if (!stat.stack_empty) begin
                     cmd.pop_rd = 1'b1;
                     state_in   = S_POP;
                  end else if (stat.table_full) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = gsa_pkg::ST_FULL;
                     state_in       = S_RESP;
                  end else begin
                     cmd.alloc_new = 1'b1;
                     state_in      = S_RESP;
                  end
               end
               gsa_pkg::ACT_RELEASE, gsa_pkg::ACT_LOOKUP: begin
                  if (!stat.id_in_range) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = gsa_pkg::ST_BAD_ID;
                     state_in       = S_RESP;
                  end else begin
                     cmd.slot_rd = 1'b1;
                     state_in    = S_SLOT;
                  end
               end
               gsa_pkg::ACT_REL_OWNER: begin
                  if (stat.owner_zero) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = gsa_pkg::ST_BAD_OWNER;
                     state_in       = S_RESP;
                  end else begin
                     state_in = S_WALK;
                  end
               end
               gsa_pkg::ACT_REL_ALL: begin
                  state_in = S_WALK;
               end
               default: begin
                  state_in = S_RESP;
               end
            endcase
         end
         S_POP: begin
            cmd.gen_rd = 1'b1;
            state_in   = S_GEN;
         end
         S_GEN: begin
            cmd.alloc_reuse = 1'b1;
            state_in        = S_RESP;
         end
         S_SLOT: begin
            if (!stat.slot_hit) begin
               cmd.set_status = 1'b1;
               cmd.status     = gsa_pkg::ST_BAD_ID;
            end else if (stat.action == gsa_pkg::ACT_RELEASE) begin
               cmd.free_one = 1'b1;
            end else begin
               cmd.lookup_done = 1'b1;
            end
            state_in = S_RESP;
         end
         S_WALK: begin
            cmd.walk_step = 1'b1;
            if (stat.walk_done) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

endmodule

>>> rtl/core/generational_slot_allocator.sv
// Generational slot allocator: one request at a time. After accept the request is decoded;
// allocate of a new slot, unused actions and requests rejected at decode go straight to the result;
// release/lookup first read the slot; allocate from the free stack pops it, then reads the
// generation; release-by-owner/all walks the slots ever handed out, one slot per cycle through
// the generation/owner RAM read port. busy clears the cycle after the strobe; no rsp stall.
// Synchronous active-high reset: all slots unused, free stack empty. Uses gsa_ctrl, gsa_dp.
module generational_slot_allocator (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [gsa_pkg::ACTION_W-1:0]   req_action,
   input  logic [gsa_pkg::HANDLE_W-1:0]   req_instance_id,
   input  logic [gsa_pkg::OWNER_W-1:0]    req_owner_tag,
   output logic                           rsp_valid,
   output logic [gsa_pkg::HANDLE_W-1:0]   rsp_result_id,
   output logic [gsa_pkg::STATUS_W-1:0]   rsp_status,
   output logic [gsa_pkg::OWNER_W-1:0]    rsp_owner_out,
   output logic [gsa_pkg::RCNT_W-1:0]     rsp_released_count
);

   gsa_pkg::dp_cmd_type  cmd;
   gsa_pkg::dp_stat_type stat;

   gsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .stat      (stat)
   );

   gsa_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_action         (req_action),
      .req_instance_id    (req_instance_id),
      .req_owner_tag      (req_owner_tag),
      .rsp_result_id      (rsp_result_id),
      .rsp_status         (rsp_status),
      .rsp_owner_out      (rsp_owner_out),
      .rsp_released_count (rsp_released_count)
   );

endmodule

>>> rtl/core/gsa_checker.sv
// Port-level checks for the generational slot allocator, bound to the top level.
// Depends on gsa_pkg and generational_slot_allocator.
module gsa_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic                          rsp_valid,
   input logic [gsa_pkg::HANDLE_W-1:0]  rsp_result_id,
   input logic [gsa_pkg::STATUS_W-1:0]  rsp_status,
   input logic [gsa_pkg::OWNER_W-1:0]   rsp_owner_out,
   input logic [gsa_pkg::RCNT_W-1:0]    rsp_released_count
);

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy low after request accepted");

   a_result_single_cycle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_fail_no_id: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != gsa_pkg::ST_OK)) |->
      ((rsp_result_id == '0) && (rsp_owner_out == '0) && (rsp_released_count == '0)))
      else $error("failed request returned data");

   a_release_exclusive: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_released_count != '0)) |->
      ((rsp_result_id == '0) && (rsp_owner_out == '0)))
      else $error("release result carries id or owner");

endmodule

bind generational_slot_allocator gsa_checker u_gsa_checker (
   .clock              (clock),
   .reset              (reset),
   .start              (start),
   .busy               (busy),
   .rsp_valid          (rsp_valid),
   .rsp_result_id      (rsp_result_id),
   .rsp_status         (rsp_status),
   .rsp_owner_out      (rsp_owner_out),
   .rsp_released_count (rsp_released_count)
);

>>> dv/tb.sv
// Self-checking bench for generational_slot_allocator: a directed table of requests, then
// random traffic of all actions; checked against listed results or an in-bench slot table.
// Depends on gsa_pkg and the RTL under rtl/core.
module tb;
   import gsa_pkg::*;

   localparam logic [ACTION_W-1:0] ACT_UNUSED5 = 3'd5;
   localparam logic [ACTION_W-1:0] ACT_UNUSED6 = 3'd6;
   localparam logic [ACTION_W-1:0] ACT_UNUSED7 = 3'd7;
   localparam int RANDOM_PER_PHASE = 356;
   localparam int SEGMENT_LEN = 80;
   localparam int SETTLE_CYCLES = SLOT_COUNT + 16;
   localparam int MAX_REPORTS = 10;
   localparam int OWNER_POOL = 5;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [HANDLE_W-1:0] id;
      logic [OWNER_W-1:0]  owner;
   } slot_request_type;

   typedef struct packed {
      logic [HANDLE_W-1:0] id;
      status_type          status;
      logic [OWNER_W-1:0]  owner;
      logic [RCNT_W-1:0]   count;
   } slot_result_type;

   typedef struct {
      slot_request_type q;
      bit               typed;
      slot_result_type  r;
   } directed_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [ACTION_W-1:0] req_action = '0;
   logic [HANDLE_W-1:0] req_instance_id = '0;
   logic [OWNER_W-1:0]  req_owner_tag = '0;
   logic                rsp_valid;
   logic [HANDLE_W-1:0] rsp_result_id;
   logic [STATUS_W-1:0] rsp_status;
   logic [OWNER_W-1:0]  rsp_owner_out;
   logic [RCNT_W-1:0]   rsp_released_count;

   // slot table as the block should hold it
   logic [GEN_BITS-1:0] tbl_gen [SLOT_COUNT];
   bit                  tbl_live [SLOT_COUNT];
   logic [OWNER_W-1:0]  tbl_owner [SLOT_COUNT];
   int                  tbl_mark = 0;
   int                  free_lifo [SLOT_COUNT];
   int                  free_depth = 0;

   slot_result_type     pending_results [$];
   directed_row_type    directed_rows [$];
   logic [OWNER_W-1:0]  owner_pool [OWNER_POOL];
   int                  sender_idle_pct = 0;
   int                  n_mismatch = 0;
   int                  n_checked = 0;
   int                  n_requests = 0;
   int                  n_by_status [4] = '{0, 0, 0, 0};
   int                  n_freed = 0;
   int                  n_walks = 0;

   generational_slot_allocator u_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_action         (req_action),
      .req_instance_id    (req_instance_id),
      .req_owner_tag      (req_owner_tag),
      .rsp_valid          (rsp_valid),
      .rsp_result_id      (rsp_result_id),
      .rsp_status         (rsp_status),
      .rsp_owner_out      (rsp_owner_out),
      .rsp_released_count (rsp_released_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #10_000_000;
      $display("tb failed");
      $finish;
   end

   function automatic logic [HANDLE_W-1:0] handle_of(input int idx,
                                                     input logic [GEN_BITS-1:0] gen);
      return {HGEN_W'(gen), HIDX_W'(idx + 1)};
   endfunction

   // slot named by a current handle, or -1
   function automatic int slot_of(input logic [HANDLE_W-1:0] id);
      int idx;
      idx = int'(id[HIDX_W-1:0]);
      if (idx == 0) return -1;
      idx = idx - 1;
      if (idx >= tbl_mark) return -1;
      if (HGEN_W'(tbl_gen[idx]) != id[HANDLE_W-1:HIDX_W]) return -1;
      return idx;
   endfunction

   function automatic void retire_slot(input int idx);
      tbl_live[idx] = 1'b0;
      tbl_gen[idx] = tbl_gen[idx] + 1'b1;
      if (free_depth < SLOT_COUNT) begin
         free_lifo[free_depth] = idx;
         free_depth++;
      end
   endfunction

   function automatic slot_result_type slot_table_apply(input slot_request_type q);
      slot_result_type r;
      int idx;
      r = '0;
      r.status = ST_OK;
      case (q.action)
         ACT_ALLOC: begin
            if (q.owner == '0) begin
               r.status = ST_BAD_OWNER;
            end else if (free_depth == 0 && tbl_mark >= SLOT_COUNT) begin
               r.status = ST_FULL;
            end else begin
               if (free_depth > 0) begin
                  free_depth--;
                  idx = free_lifo[free_depth];
               end else begin
                  idx = tbl_mark;
                  tbl_mark++;
                  tbl_gen[idx] = '0;
               end
               tbl_owner[idx] = q.owner;
               tbl_live[idx] = 1'b1;
               r.id = handle_of(idx, tbl_gen[idx]);
            end
         end
         ACT_RELEASE, ACT_LOOKUP: begin
            idx = slot_of(q.id);
            if (idx < 0 || !tbl_live[idx]) begin
               r.status = ST_BAD_ID;
            end else if (q.action == ACT_RELEASE) begin
               retire_slot(idx);
               r.count = RCNT_W'(1);
            end else begin
               r.owner = tbl_owner[idx];
            end
         end
         ACT_REL_OWNER, ACT_REL_ALL: begin
            if (q.action == ACT_REL_OWNER && q.owner == '0) begin
               r.status = ST_BAD_OWNER;
            end else begin
               for (int i = 0; i < tbl_mark; i++) begin
                  if (tbl_live[i] && (q.action == ACT_REL_ALL || tbl_owner[i] == q.owner)) begin
                     retire_slot(i);
                     r.count++;
                  end
               end
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic int random_live_slot();
      int hits [$];
      for (int i = 0; i < tbl_mark; i++) begin
         if (tbl_live[i]) hits = {hits, i};
      end
      if (hits.size() == 0) return -1;
      return hits[$urandom_range(hits.size() - 1)];
   endfunction

   function automatic slot_request_type random_request(input int alloc_pct);
      slot_request_type q;
      int pick;
      int idx;
      logic [GEN_BITS-1:0] gen;
      q.action = ACT_LOOKUP;
      q.id = $urandom;
      q.owner = owner_pool[$urandom_range(OWNER_POOL - 1)];
      if ($urandom_range(19) == 0) q.owner = $urandom;
      if ($urandom_range(39) == 0) q.owner = '0;
      pick = $urandom_range(99);
      if ($urandom_range(99) < alloc_pct) begin
         q.action = ACT_ALLOC;
      end else if (pick < 70) begin
         q.action = (pick < 45) ? ACT_RELEASE : ACT_LOOKUP;
         idx = random_live_slot();
         if (idx >= 0) q.id = handle_of(idx, tbl_gen[idx]);
      end else if (pick < 88) begin
         q.action = $urandom_range(1) ? ACT_RELEASE : ACT_LOOKUP;
         case ($urandom_range(3))
            0: q.id[HIDX_W-1:0] = '0;
            1: q.id[HIDX_W-1:0] = HIDX_W'($urandom_range(255, tbl_mark + 1));
            default: begin
               if (tbl_mark > 0) begin
                  idx = $urandom_range(tbl_mark - 1);
                  gen = tbl_gen[idx];
                  case ($urandom_range(3))
                     0: gen = gen - 1'b1;
                     1: gen = gen + 1'b1;
                     2: gen = GEN_BITS'($urandom);
                     default: ;
                  endcase
                  q.id = handle_of(idx, gen);
               end
            end
         endcase
      end else if (pick < 95) begin
         q.action = ACT_REL_OWNER;
      end else if (pick < 97) begin
         q.action = ACT_REL_ALL;
      end else begin
         q.action = ACTION_W'($urandom_range(ACT_UNUSED7, ACT_UNUSED5));
      end
      return q;
   endfunction

   task automatic add_row(input logic [ACTION_W-1:0] act, input logic [HANDLE_W-1:0] id,
                          input logic [OWNER_W-1:0] owner, input bit typed,
                          input logic [HANDLE_W-1:0] e_id, input status_type e_st,
                          input logic [OWNER_W-1:0] e_own, input logic [RCNT_W-1:0] e_cnt);
      directed_row_type row;
      row.q = '{act, id, owner};
      row.typed = typed;
      row.r = '{e_id, e_st, e_own, e_cnt};
      directed_rows = {directed_rows, row};
   endtask

   task automatic send_request(input slot_request_type q, input bit typed,
                               input slot_result_type typed_res);
      slot_result_type predicted;
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_action <= q.action;
      req_instance_id <= q.id;
      req_owner_tag <= q.owner;
      do @(posedge clock); while (busy);
      predicted = slot_table_apply(q);
      pending_results = {pending_results, (typed ? typed_res : predicted)};
      n_requests++;
      n_by_status[predicted.status]++;
      n_freed += predicted.count;
      if (q.action == ACT_REL_OWNER || q.action == ACT_REL_ALL) n_walks++;
   endtask

   always @(posedge clock) begin
      slot_result_type seen;
      slot_result_type want;
      if (!reset && rsp_valid) begin
         seen.id = rsp_result_id;
         seen.status = status_type'(rsp_status);
         seen.owner = rsp_owner_out;
         seen.count = rsp_released_count;
         if (pending_results.size() == 0) begin
            n_mismatch++;
            if (n_mismatch <= MAX_REPORTS)
               $display("unexpected result: id=%h status=%0d owner=%h count=%0d",
                        seen.id, seen.status, seen.owner, seen.count);
         end else begin
            want = pending_results.pop_front();
            n_checked++;
            if (seen.id !== want.id || seen.status !== want.status ||
                seen.owner !== want.owner || seen.count !== want.count) begin
               n_mismatch++;
               if (n_mismatch <= MAX_REPORTS)
                  $display({"mismatch at result %0d: expected id=%h status=%0d owner=%h ",
                            "count=%0d, got id=%h status=%0d owner=%h count=%0d"},
                           n_checked, want.id, want.status, want.owner, want.count,
                           seen.id, seen.status, seen.owner, seen.count);
            end
         end
      end
   end

   initial begin
      int idle_by_phase [4];
      int alloc_pct;
      slot_request_type q;
      idle_by_phase = '{0, 68, 0, 29};
      owner_pool[0] = 32'h0000_0001;
      owner_pool[1] = 32'hFFFF_FFFF;
      owner_pool[2] = 32'h8000_0000;
      owner_pool[3] = $urandom | 32'h1;
      owner_pool[4] = $urandom | 32'h1;

      add_row(ACT_LOOKUP,    32'h0000_0000, 32'h0,         1, 32'h0, ST_BAD_ID, 32'h0, 0);
      add_row(ACT_RELEASE,   32'hFFFF_FFFF, 32'h0,         1, 32'h0, ST_BAD_ID, 32'h0, 0);
      add_row(ACT_REL_ALL,   32'h0,         32'h0,         1, 32'h0, ST_OK, 32'h0, 0);
      add_row(ACT_ALLOC,     32'h0,         32'h0,         1, 32'h0, ST_BAD_OWNER, 32'h0, 0);
      add_row(ACT_REL_OWNER, 32'h0,         32'h0,         1, 32'h0, ST_BAD_OWNER, 32'h0, 0);
      add_row(ACT_ALLOC,     32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 32'h0000_0001, ST_OK, 32'h0, 0);
      add_row(ACT_ALLOC,     32'h0,         32'h0000_0001, 1, 32'h0000_0002, ST_OK, 32'h0, 0);
      add_row(ACT_LOOKUP,    32'h0000_0001, 32'h0,         1, 32'h0, ST_OK, 32'hFFFF_FFFF, 0);
      add_row(ACT_LOOKUP,    32'h0000_0101, 32'h0,         1, 32'h0, ST_BAD_ID, 32'h0, 0);
      add_row(ACT_LOOKUP,    32'hFFFF_FF01, 32'h0,         1, 32'h0, ST_BAD_ID, 32'h0, 0);
      add_row(ACT_LOOKUP,    32'h0000_0003, 32'h0,         1, 32'h0, ST_BAD_ID, 32'h0, 0);
      add_row(ACT_RELEASE,   32'h0000_0001, 32'h0,         1, 32'h0, ST_OK, 32'h0, 1);
      add_row(ACT_RELEASE,   32'h0000_0001, 32'h0,         1, 32'h0, ST_BAD_ID, 32'h0, 0);
      // current generation, but slot already free
      add_row(ACT_RELEASE,   32'h0000_0101, 32'h0,         1, 32'h0, ST_BAD_ID, 32'h0, 0);
      add_row(ACT_ALLOC,     32'h0,         32'hA5A5_A5A5, 1, 32'h0000_0101, ST_OK, 32'h0, 0);
      add_row(ACT_ALLOC,     32'h0,         owner_pool[3], 0, 32'h0, ST_OK, 32'h0, 0);
      add_row(ACT_REL_OWNER, 32'h0,         32'h0000_0001, 1, 32'h0, ST_OK, 32'h0, 1);
      add_row(ACT_LOOKUP,    32'h0000_0102, 32'h0,         1, 32'h0, ST_BAD_ID, 32'h0, 0);
      add_row(ACT_UNUSED5,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 32'h0, ST_OK, 32'h0, 0);
      add_row(ACT_UNUSED6,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 32'h0, ST_OK, 32'h0, 0);
      add_row(ACT_UNUSED7,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 32'h0, ST_OK, 32'h0, 0);
      add_row(ACT_REL_OWNER, 32'h0,         32'hFFFF_FFFF, 0, 32'h0, ST_OK, 32'h0, 0);
      add_row(ACT_REL_ALL,   32'h0,         32'h0,         1, 32'h0, ST_OK, 32'h0, 2);
      add_row(ACT_LOOKUP,    32'h0000_0101, 32'h0,         1, 32'h0, ST_BAD_ID, 32'h0, 0);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_request(directed_rows[i].q, directed_rows[i].typed, directed_rows[i].r);

      for (int phase = 0; phase < 4; phase++) begin
         sender_idle_pct = idle_by_phase[phase];
         alloc_pct = 90;
         for (int n = 0; n < RANDOM_PER_PHASE; ) begin
            // first segment of a phase fills the table; later ones drift
            if (n > 0 && n % SEGMENT_LEN == 0) alloc_pct = $urandom_range(85, 10);
            q = random_request(alloc_pct);
            send_request(q, 0, '0);
            if (q.action <= ACT_REL_ALL) n++;
         end
      end
      start <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("%0d requests, %0d results checked: %0d ok, %0d full, %0d bad id, %0d bad owner",
               n_requests, n_checked, n_by_status[ST_OK], n_by_status[ST_FULL],
               n_by_status[ST_BAD_ID], n_by_status[ST_BAD_OWNER]);
      $display("%0d slots freed, %0d owner/all walks, %0d mismatches",
               n_freed, n_walks, n_mismatch);
      if (n_mismatch == 0)
         $display("tb passed");
      else
         $display("tb failed");
      $finish;
   end

endmodule
